FILE: hw/rtl/dlq_pkg.sv
// ----------------------------------------------------------------------------
// dlq_pkg
// Operation codes, status codes and the result record shared by the timer
// queue modules.
// ----------------------------------------------------------------------------
package dlq_pkg;

	typedef enum logic [1:0] {
		OP_ADD      = 2'd0,
		OP_TICK     = 2'd1,
		OP_DISPATCH = 2'd2,
		OP_DELETE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_NOT_DUE   = 2'd3
	} status_t;

	// One result record as it leaves the controller.
	typedef struct packed {
		status_t     status;
		logic [15:0] new_id;
		logic        fired;
		logic [7:0]  fired_tag;
		logic [15:0] fired_id;
	} res_t;

	localparam int unsigned FIELD_TIME_W  = 16;
	localparam int unsigned FIELD_IDENT_W = 16;
	localparam int unsigned FIELD_TAG_W   = 8;

endpackage

FILE: hw/rtl/dlq_ram.sv
// ----------------------------------------------------------------------------
// dlq_ram
// Simple dual-port synchronous memory: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module dlq_ram #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned WIDTH = 56
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/dlq_ctrl.sv
// ----------------------------------------------------------------------------
// dlq_ctrl
// Sequencer for the delta list: walks, shifts and patches the entry memory
// one entry at a time and builds one result record per operation.
// ----------------------------------------------------------------------------
module dlq_ctrl #(
	parameter int unsigned MAX_ENTRIES = 16,
	parameter int unsigned TIME_BITS   = 16,
	parameter int unsigned IDENT_BITS  = 16,
	localparam int unsigned AW = $clog2(MAX_ENTRIES),
	localparam int unsigned EW = 2 * TIME_BITS + dlq_pkg::FIELD_TAG_W + IDENT_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dlq_pkg::op_t   op,
	input  logic [15:0]    delay,
	input  logic [15:0]    period,
	input  logic [7:0]     task_tag,
	input  logic [15:0]    task_id,
	output logic           res_valid,
	input  logic           res_ready,
	output dlq_pkg::res_t  res,
	output logic           wr_en,
	output logic [AW-1:0]  wr_addr,
	output logic [EW-1:0]  wr_data,
	output logic           rd_en,
	output logic [AW-1:0]  rd_addr,
	input  logic [EW-1:0]  rd_data
);

	localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned TB    = TIME_BITS;
	localparam int unsigned IB    = IDENT_BITS;
	localparam int unsigned TGW   = dlq_pkg::FIELD_TAG_W;
	localparam int unsigned SW    = (TB > dlq_pkg::FIELD_TIME_W) ? TB : dlq_pkg::FIELD_TIME_W;
	localparam int unsigned CW    = (IB > dlq_pkg::FIELD_IDENT_W) ? IB : dlq_pkg::FIELD_IDENT_W;
	localparam logic [TB-1:0] TIME_MAX = {TB{1'b1}};

	typedef enum logic [3:0] {
		S_IDLE, S_WALK_RD, S_WALK_EV, S_SHIFT_UP, S_INSERT, S_TICK_EV,
		S_DISP_EV, S_FIND_RD, S_FIND_EV, S_SHIFT_DN, S_DONE
	} state_t;

	// Saturate a 16-bit port value to the stored time width.
	function automatic logic [TB-1:0] sat_time(input logic [15:0] v);
		logic [SW-1:0] w;
		w = SW'(v);
		return (w > SW'(TIME_MAX)) ? TIME_MAX : w[TB-1:0];
	endfunction

	function automatic logic [15:0] id_out(input logic [IB-1:0] v);
		logic [CW-1:0] w;
		w = CW'(v);
		return w[15:0];
	endfunction

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [IB-1:0]     next_id_q;
	dlq_pkg::op_t      op_q;
	logic [TB-1:0]     delay_q;
	logic [TB-1:0]     period_q;
	logic [TGW-1:0]    tag_q;
	logic [IB-1:0]     ident_q;
	logic [15:0]       want_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  slot_q;
	logic [TB-1:0]     sum_q;
	logic [TB-1:0]     newd_q;
	logic [TB-1:0]     remd_q;
	dlq_pkg::res_t     res_q;
	logic              mv_s1;
	logic              mv_up_s1;
	logic [AW-1:0]     mv_dst_s1;

	logic [TB-1:0]     rd_delta;
	logic [TB-1:0]     rd_period;
	logic [TGW-1:0]    rd_tag;
	logic [IB-1:0]     rd_ident;
	logic [CNT_W-1:0]  ptr_inc;
	logic [CNT_W-1:0]  ptr_dec;
	logic [CNT_W-1:0]  slot_inc;
	logic [TB:0]       walk_sum;
	logic [TB:0]       join_sum;
	logic [TB-1:0]     mv_delta;
	logic [IB-1:0]     next_id_inc;
	logic              id_match;

	assign rd_ident  = rd_data[IB-1:0];
	assign rd_tag    = rd_data[IB+TGW-1:IB];
	assign rd_period = rd_data[IB+TGW+TB-1:IB+TGW];
	assign rd_delta  = rd_data[EW-1:EW-TB];

	assign ptr_inc     = ptr_q + CNT_W'(1);
	assign ptr_dec     = ptr_q - CNT_W'(1);
	assign slot_inc    = slot_q + CNT_W'(1);
	assign walk_sum    = {1'b0, sum_q} + {1'b0, rd_delta};
	assign join_sum    = {1'b0, rd_delta} + {1'b0, remd_q};
	assign next_id_inc = next_id_q + IB'(1);
	assign id_match    = (CW'(rd_ident) == CW'(want_q));

	// Delta of an entry being moved: the one pushed behind a new entry gives
	// up the new entry's delta, the one closing a gap takes the removed delta.
	always_comb begin
		mv_delta = rd_delta;
		if (mv_up_s1 && (CNT_W'(mv_dst_s1) == slot_inc)) begin
			mv_delta = rd_delta - newd_q;
		end else if (!mv_up_s1 && (CNT_W'(mv_dst_s1) == slot_q)) begin
			mv_delta = join_sum[TB] ? TIME_MAX : join_sum[TB-1:0];
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				rd_en   = in_valid && (count_q != '0) &&
					((op == dlq_pkg::OP_TICK) || (op == dlq_pkg::OP_DISPATCH));
				rd_addr = '0;
			end
			S_WALK_RD, S_FIND_RD: rd_en = (ptr_q != count_q);
			S_SHIFT_UP: begin
				rd_en   = (ptr_q > slot_q);
				rd_addr = ptr_dec[AW-1:0];
			end
			S_SHIFT_DN: begin
				rd_en   = (ptr_inc < count_q);
				rd_addr = ptr_inc[AW-1:0];
			end
			default: rd_en = 1'b0;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = mv_dst_s1;
		wr_data = {mv_delta, rd_period, rd_tag, rd_ident};
		if (mv_s1) begin
			wr_en = 1'b1;
		end else if (state_q == S_INSERT) begin
			wr_en   = 1'b1;
			wr_addr = slot_q[AW-1:0];
			wr_data = {newd_q, period_q, tag_q, ident_q};
		end else if ((state_q == S_TICK_EV) && (rd_delta != '0)) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = {rd_delta - TB'(1), rd_period, rd_tag, rd_ident};
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			next_id_q <= IB'(1);
			mv_s1     <= 1'b0;
			mv_up_s1  <= 1'b0;
			mv_dst_s1 <= '0;
			op_q      <= dlq_pkg::OP_ADD;
			delay_q   <= '0;
			period_q  <= '0;
			tag_q     <= '0;
			ident_q   <= '0;
			want_q    <= '0;
			ptr_q     <= '0;
			slot_q    <= '0;
			sum_q     <= '0;
			newd_q    <= '0;
			remd_q    <= '0;
			res_q     <= '0;
		end else begin
			mv_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						res_q    <= '0;
						op_q     <= op;
						delay_q  <= sat_time(delay);
						period_q <= sat_time(period);
						tag_q    <= task_tag;
						want_q   <= task_id;
						ptr_q    <= '0;
						sum_q    <= '0;
						unique case (op)
							dlq_pkg::OP_ADD: begin
								if (count_q == CNT_W'(MAX_ENTRIES)) begin
									res_q.status <= dlq_pkg::ST_FULL;
									state_q      <= S_DONE;
								end else begin
									ident_q      <= next_id_q;
									next_id_q    <= (next_id_inc == '0) ? IB'(1) : next_id_inc;
									res_q.new_id <= id_out(next_id_q);
									state_q      <= S_WALK_RD;
								end
							end
							dlq_pkg::OP_TICK: begin
								state_q <= (count_q == '0) ? S_DONE : S_TICK_EV;
							end
							dlq_pkg::OP_DISPATCH: begin
								if (count_q == '0) begin
									res_q.status <= dlq_pkg::ST_NOT_DUE;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_DISP_EV;
								end
							end
							dlq_pkg::OP_DELETE: begin
								if (task_id == '0) begin
									res_q.status <= dlq_pkg::ST_NOT_FOUND;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_FIND_RD;
								end
							end
						endcase
					end
				end
				S_WALK_RD: begin
					if (ptr_q == count_q) begin
						slot_q  <= ptr_q;
						newd_q  <= delay_q - sum_q;
						state_q <= S_SHIFT_UP;
					end else begin
						state_q <= S_WALK_EV;
					end
				end
				S_WALK_EV: begin
					if ({1'b0, delay_q} < walk_sum) begin
						slot_q  <= ptr_q;
						newd_q  <= delay_q - sum_q;
						ptr_q   <= count_q;
						state_q <= S_SHIFT_UP;
					end else begin
						sum_q   <= walk_sum[TB-1:0];
						ptr_q   <= ptr_inc;
						state_q <= S_WALK_RD;
					end
				end
				S_SHIFT_UP: begin
					if (ptr_q > slot_q) begin
						ptr_q     <= ptr_dec;
						mv_s1     <= 1'b1;
						mv_up_s1  <= 1'b1;
						mv_dst_s1 <= ptr_q[AW-1:0];
					end else if (!mv_s1) begin
						state_q <= S_INSERT;
					end
				end
				S_INSERT: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_TICK_EV: state_q <= S_DONE;
				S_DISP_EV: begin
					if (rd_delta != '0) begin
						res_q.status <= dlq_pkg::ST_NOT_DUE;
						state_q      <= S_DONE;
					end else begin
						res_q.fired     <= 1'b1;
						res_q.fired_tag <= rd_tag;
						res_q.fired_id  <= id_out(rd_ident);
						delay_q         <= rd_period;
						period_q        <= rd_period;
						tag_q           <= rd_tag;
						ident_q         <= rd_ident;
						slot_q          <= '0;
						ptr_q           <= '0;
						remd_q          <= '0;
						state_q         <= S_SHIFT_DN;
					end
				end
				S_FIND_RD: begin
					if (ptr_q == count_q) begin
						res_q.status <= dlq_pkg::ST_NOT_FOUND;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_FIND_EV;
					end
				end
				S_FIND_EV: begin
					if (id_match) begin
						slot_q  <= ptr_q;
						remd_q  <= rd_delta;
						state_q <= S_SHIFT_DN;
					end else begin
						ptr_q   <= ptr_inc;
						state_q <= S_FIND_RD;
					end
				end
				S_SHIFT_DN: begin
					if (ptr_inc < count_q) begin
						ptr_q     <= ptr_inc;
						mv_s1     <= 1'b1;
						mv_up_s1  <= 1'b0;
						mv_dst_s1 <= ptr_q[AW-1:0];
					end else if (!mv_s1) begin
						count_q <= count_q - CNT_W'(1);
						if ((op_q == dlq_pkg::OP_DISPATCH) && (period_q != '0)) begin
							// A periodic task goes back in with its period as delay.
							ptr_q   <= '0;
							sum_q   <= '0;
							state_q <= S_WALK_RD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/delta_list_timer_queue.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Timer queue kept as a sorted delta list in a single entry memory.
// ----------------------------------------------------------------------------
// The queue holds up to MAX_ENTRIES timed tasks in order of due time; each
// entry stores its delay relative to the entry in front of it, so only the
// head counts down. Each transfer on the slave side carries one operation
// (add, tick, dispatch or delete) and produces exactly one result transfer
// on the master side. Operations are handled one at a time by a sequencer
// that works on the entry memory, which has one read and one write port and
// registered read data, so the memory port sets the cost. Tick counts the
// head down. Add walks the entries before the insertion slot, moves each
// entry behind it and writes the new entry. Delete searches the entries up
// to the match and moves each entry after the match. Dispatch pops the head
// when it is due and, for a periodic task, does a further add walk to put
// it back. A new operation is taken as soon as the previous result has been
// handed to the output register, even while that result still waits for
// the downstream side. There is no clearing pass after reset: entries
// beyond the fill count are never read.
// ----------------------------------------------------------------------------
module delta_list_timer_queue #(
	parameter int unsigned MAX_ENTRIES = 16,
	parameter int unsigned TIME_BITS   = 16,
	parameter int unsigned IDENT_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // delay[15:0], period[31:16], task_tag[39:32], task_id[55:40]
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // new_id[15:0], fired_tag[23:16], fired_id[39:24]
	output logic [2:0]  m_tuser    // status[1:0], fired[2]
);

	localparam int unsigned AW = $clog2(MAX_ENTRIES);
	localparam int unsigned EW = 2 * TIME_BITS + dlq_pkg::FIELD_TAG_W + IDENT_BITS;

	logic           res_valid;
	logic           res_ready;
	dlq_pkg::res_t  res;
	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	logic [EW-1:0]  wr_data;
	logic           rd_en;
	logic [AW-1:0]  rd_addr;
	logic [EW-1:0]  rd_data;

	logic           m_tvalid_q;
	dlq_pkg::res_t  out_q;

	dlq_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.TIME_BITS   (TIME_BITS),
		.IDENT_BITS  (IDENT_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.op        (dlq_pkg::op_t'(s_tuser)),
		.delay     (s_tdata[15:0]),
		.period    (s_tdata[31:16]),
		.task_tag  (s_tdata[39:32]),
		.task_id   (s_tdata[55:40]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	dlq_ram #(
		.DEPTH (MAX_ENTRIES),
		.WIDTH (EW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Output register: it frees the sequencer as soon as a result is loaded,
	// and is refilled in the same cycle that its contents are taken.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_q.fired_id, out_q.fired_tag, out_q.new_id};
	assign m_tuser  = {out_q.fired, out_q.status};

endmodule
